/* design/lpht_pkg.sv */
// Package for the linear probing hash table: sizes, slot marks, commands, status codes.
// No dependencies.
package lpht_pkg;
  localparam int Slots = 1024;
  localparam int IdxW = $clog2(Slots);
  localparam int CntW = IdxW + 1;
  localparam int LoadNum = 7;
  localparam int LoadDen = 10;
  // Load limit in slots: load*10 >= Slots*7  <=>  load >= ceil(Slots*7/10).
  localparam int LoadLimit = (Slots * LoadNum + LoadDen - 1) / LoadDen;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2,
    MARK_ODD   = 2'd3
  } mark_t;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_MISS    = 2'd1,
    ST_NEW     = 2'd2,
    ST_REFUSED = 2'd3
  } status_t;

  typedef struct packed {
    logic [63:0] key;
    logic [7:0]  bucket;
    logic [47:0] offset;
    logic [47:0] length;
  } entry_t;
endpackage

/* design/linear_probe_hash_table.sv */
// Top level of the linear probing hash table: probe sequencer, slot memories, counters.
// Depends on lpht_pkg.
//
//  channel | handshake                       | payload
//  request | start, busy; accept start&!busy | command, key_hash, bucket_in,
//          |                                 | offset_in, length_in
//  result  | done (one cycle, no stall)      | status, bucket_out, offset_out,
//          |                                 | length_out, live_count, tomb_count
//
// A request probes n slots, n in 1..Slots; a CMD_NONE command skips the probe. Each probe
// step is one read of the slot memories, in S_READ, and its check in S_CHECK. The write back
// lands at the edge that raises done. Busy is high from accept until done rises; the next
// request can be accepted at the edge that ends the done cycle. After reset a clearing pass
// empties the mark memory slot by slot; busy stays high meanwhile. The receiver cannot stall:
// done lasts exactly one cycle.
module linear_probe_hash_table (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  logic [1:0]   command,
  input  logic [63:0]  key_hash,
  input  logic [7:0]   bucket_in,
  input  logic [47:0]  offset_in,
  input  logic [47:0]  length_in,
  output logic         done,
  output logic [1:0]   status,
  output logic [7:0]   bucket_out,
  output logic [47:0]  offset_out,
  output logic [47:0]  length_out,
  output logic [10:0]  live_count,
  output logic [10:0]  tomb_count
);
  import lpht_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_CHECK, S_DONE
  } state_t;

  // Slot memories: marks and entries.
  logic [1:0] mark_mem [Slots];
  entry_t     ent_mem  [Slots];

  state_t      state;
  logic [IdxW-1:0] addr;
  logic [CntW-1:0] steps;
  logic [1:0]  rd_mark;
  entry_t      rd_ent;
  cmd_t        cmd;
  entry_t      req;
  logic        tomb_seen;
  logic [IdxW-1:0] tomb_idx;
  logic [CntW-1:0] occ;
  logic [CntW-1:0] tomb;

  logic        mark_we;
  logic [1:0]  mark_wd;
  logic        ent_we;
  entry_t      ent_wd;
  logic [IdxW-1:0] wr_addr;

  // Synchronous memory read and write.
  always_ff @(posedge clk) begin
    rd_mark <= mark_mem[addr];
    rd_ent  <= ent_mem[addr];
    if (mark_we) begin
      mark_mem[wr_addr] <= mark_wd;
    end
    if (ent_we) begin
      ent_mem[wr_addr] <= ent_wd;
    end
  end

  // Decision on the slot just read.
  logic is_empty, is_hit, last_step, load_full, cur_tomb;
  logic [IdxW-1:0] place;
  logic can_place;
  always_comb begin
    is_empty  = (rd_mark == MARK_EMPTY);
    is_hit    = (rd_mark == MARK_LIVE) && (rd_ent.key == req.key);
    cur_tomb  = !is_empty && (rd_mark != MARK_LIVE);
    last_step = (steps == CntW'(Slots));
    load_full = ((occ + tomb) >= CntW'(LoadLimit));
    place     = tomb_seen ? tomb_idx : addr;
    can_place = tomb_seen || is_empty || cur_tomb;
  end

  // Sequencer: one clocked block holds state, counters and result registers.
  always_ff @(posedge clk) begin
    mark_we <= 1'b0;
    ent_we  <= 1'b0;
    done    <= 1'b0;
    if (rst) begin
      state   <= S_CLEAR;
      addr    <= '0;
      busy    <= 1'b1;
      occ     <= '0;
      tomb    <= '0;
      mark_we <= 1'b1;
      mark_wd <= MARK_EMPTY;
      wr_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          wr_addr <= wr_addr + 1'b1;
          mark_we <= (wr_addr != IdxW'(Slots - 1));
          if (wr_addr == IdxW'(Slots - 1)) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start) begin
            busy       <= 1'b1;
            cmd        <= cmd_t'(command);
            req        <= '{key_hash, bucket_in, offset_in, length_in};
            addr       <= key_hash[IdxW-1:0];
            steps      <= CntW'(1);
            tomb_seen  <= 1'b0;
            bucket_out <= '0;
            offset_out <= '0;
            length_out <= '0;
            status     <= ST_MISS;
            state      <= (cmd_t'(command) == CMD_NONE) ? S_DONE : S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (!is_empty && !is_hit && !tomb_seen && rd_mark != MARK_LIVE) begin
            tomb_seen <= 1'b1;
            tomb_idx  <= addr;
          end
          if (is_hit) begin
            state  <= S_DONE;
            status <= ST_HIT;
            unique case (cmd)
              CMD_LOOKUP: begin
                bucket_out <= rd_ent.bucket;
                offset_out <= rd_ent.offset;
                length_out <= rd_ent.length;
              end
              CMD_INSERT: begin
                ent_we  <= 1'b1;
                wr_addr <= addr;
                ent_wd  <= req;
              end
              CMD_DELETE: begin
                mark_we <= 1'b1;
                wr_addr <= addr;
                mark_wd <= MARK_TOMB;
                if (occ != '0) occ <= occ - 1'b1;
                tomb <= tomb + 1'b1;
              end
              default: ;
            endcase
          end else if (is_empty || last_step) begin
            state <= S_DONE;
            if (cmd == CMD_INSERT) begin
              if (load_full || !can_place) begin
                status <= ST_REFUSED;
              end else begin
                status  <= ST_NEW;
                mark_we <= 1'b1;
                ent_we  <= 1'b1;
                wr_addr <= place;
                mark_wd <= MARK_LIVE;
                ent_wd  <= req;
                occ     <= occ + 1'b1;
                if ((tomb_seen || cur_tomb) && tomb != '0) tomb <= tomb - 1'b1;
              end
            end
          end else begin
            addr  <= addr + 1'b1;
            steps <= steps + 1'b1;
            state <= S_READ;
          end
        end
        S_DONE: begin
          done  <= 1'b1;
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign live_count = 11'(occ);
  assign tomb_count = 11'(tomb);

`ifndef SYNTH
  // A result never appears while no request is in flight.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result without request");
  // Live count grows only through a new insert.
  a_occ_grow: assert property (@(posedge clk) disable iff (rst)
    (occ > $past(occ)) |-> (status == ST_NEW || state == S_DONE))
    else $error("live count grew unexpectedly");
  // Counts never exceed the slot count.
  a_bound: assert property (@(posedge clk) disable iff (rst)
    (occ + tomb) <= CntW'(Slots))
    else $error("counts exceed slots");
`endif
endmodule
